>>> hdl/pdir_pkg.sv
// ----------------------------------------------------------------------------
// pdir_pkg
// Shared types and constants of the pulse-distance IR frame decoder.
// ----------------------------------------------------------------------------
package pdir_pkg;

  localparam int FRAME_BITS = 24;
  localparam int DUR_W      = 16;
  localparam int NOM_W      = 16;
  localparam int TOL_W      = 7;
  localparam int FAC_W      = 8;
  localparam int FD_W       = 24;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 16;
  localparam int CNT_W      = $clog2(FRAME_BITS + 1);
  localparam int PROD_W     = NOM_W + FAC_W;
  localparam int SCALED_W   = DUR_W + 7;
  localparam int CMP_W      = (SCALED_W > PROD_W) ? SCALED_W : PROD_W;

  localparam int PCT_FULL   = 100;

  localparam logic [NOM_W-1:0] START_MARK_RST  = NOM_W'(4000);
  localparam logic [NOM_W-1:0] START_SPACE_RST = NOM_W'(4000);
  localparam logic [NOM_W-1:0] BIT_MARK_RST    = NOM_W'(550);
  localparam logic [NOM_W-1:0] ONE_SPACE_RST   = NOM_W'(2000);
  localparam logic [NOM_W-1:0] ZERO_SPACE_RST  = NOM_W'(1000);
  localparam logic [TOL_W-1:0] TOLERANCE_RST   = TOL_W'(25);

  typedef logic [DUR_W-1:0]      dur_t;
  typedef logic [NOM_W-1:0]      nom_t;
  typedef logic [TOL_W-1:0]      tol_t;
  typedef logic [FAC_W-1:0]      fac_t;
  typedef logic [PROD_W-1:0]     prod_t;
  typedef logic [CMP_W-1:0]      cmp_t;
  typedef logic [FRAME_BITS-1:0] frame_t;
  typedef logic [FD_W-1:0]       fdata_t;
  typedef logic [CNT_W-1:0]      cnt_t;
  typedef logic [CFG_IDX_W-1:0]  cfg_idx_t;
  typedef logic [CFG_DATA_W-1:0] cfg_data_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_START_MARK  = 3'd0,
    REG_START_SPACE = 3'd1,
    REG_BIT_MARK    = 3'd2,
    REG_ONE_SPACE   = 3'd3,
    REG_ZERO_SPACE  = 3'd4,
    REG_TOLERANCE   = 3'd5
  } reg_idx_t;

  typedef enum logic [3:0] {
    PH_START_MARK  = 4'b0001,
    PH_START_SPACE = 4'b0010,
    PH_BIT_MARK    = 4'b0100,
    PH_BIT_SPACE   = 4'b1000
  } phase_t;

  // Tolerance factors applied to every nominal length
  typedef struct packed {
    fac_t lo;
    fac_t hi;
  } tol_fac_t;

  // Measured duration scaled by 100, bare and with the floor slack added
  typedef struct packed {
    cmp_t base;
    cmp_t top;
  } dur_scaled_t;

endpackage

>>> hdl/pulse_distance_ir_decoder_core.sv
// ----------------------------------------------------------------------------
// pulse_distance_ir_decoder_core
// Decodes a start mark, a start space and 24 mark/space bit pairs from
// measured pulses into one frame word, or reports a framing/timing error.
//
//   channel  dir  handshake            payload
//   in_      in   in_valid/in_ready    in_is_mark, in_duration_us
//   out_     out  out_valid/out_ready  out_frame_data, out_status
//   cfg_     in   cfg_valid/cfg_ready  cfg_index, cfg_data
//
// One pulse per cycle unless a held result stalls. A pulse is captured in the
// input register and its result, if any, is registered in the output register.
// Window bounds are registered products of the configuration registers.
// cfg_ready is always high.
// Reset is synchronous: it restores default timings and returns to idle.
// A held result stalls the decode stage, which stalls the input register.
// ----------------------------------------------------------------------------
module pulse_distance_ir_decoder_core (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic               in_is_mark,
  input  pdir_pkg::dur_t     in_duration_us,
  output logic               out_valid,
  input  logic               out_ready,
  output pdir_pkg::fdata_t   out_frame_data,
  output logic               out_status,
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  pdir_pkg::cfg_idx_t cfg_index,
  input  pdir_pkg::cfg_data_t cfg_data
);
  import pdir_pkg::*;

  nom_t start_mark_r;
  nom_t start_space_r;
  nom_t bit_mark_r;
  nom_t one_space_r;
  nom_t zero_space_r;
  tol_t tol_r;

  logic ir_valid_r;
  logic ir_mark_r;
  dur_t ir_dur_r;

  phase_t phase_r;
  phase_t phase_nxt;
  cnt_t   bits_r;
  cnt_t   bits_nxt;
  frame_t shift_r;
  frame_t shift_nxt;
  frame_t shift_in;

  logic   out_valid_r;
  fdata_t out_frame_data_r;
  logic   out_status_r;

  logic   fire;
  logic   res_valid;
  logic   res_status;
  fdata_t res_data;

  tol_t        tol_c;
  tol_fac_t    fac;
  dur_scaled_t dur_sc;
  logic        hit_sm;
  logic        hit_ss;
  logic        hit_bm;
  logic        hit_one;
  logic        hit_zero;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      start_mark_r  <= START_MARK_RST;
      start_space_r <= START_SPACE_RST;
      bit_mark_r    <= BIT_MARK_RST;
      one_space_r   <= ONE_SPACE_RST;
      zero_space_r  <= ZERO_SPACE_RST;
      tol_r         <= TOLERANCE_RST;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        REG_START_MARK:  start_mark_r  <= nom_t'(cfg_data);
        REG_START_SPACE: start_space_r <= nom_t'(cfg_data);
        REG_BIT_MARK:    bit_mark_r    <= nom_t'(cfg_data);
        REG_ONE_SPACE:   one_space_r   <= nom_t'(cfg_data);
        REG_ZERO_SPACE:  zero_space_r  <= nom_t'(cfg_data);
        REG_TOLERANCE:   tol_r         <= tol_t'(cfg_data);
        default: ;
      endcase
    end
  end

  // Clamp tolerance to 100 percent
  assign tol_c  = (tol_r > tol_t'(PCT_FULL)) ? tol_t'(PCT_FULL) : tol_r;
  assign fac.lo = fac_t'(PCT_FULL) - fac_t'(tol_c);
  assign fac.hi = fac_t'(PCT_FULL) + fac_t'(tol_c);

  assign dur_sc.base = cmp_t'(ir_dur_r) * cmp_t'(PCT_FULL);
  assign dur_sc.top  = dur_sc.base + cmp_t'(PCT_FULL - 1);

  pdir_window u_win_sm (.clk, .nominal(start_mark_r),  .fac, .dur(dur_sc), .hit(hit_sm));
  pdir_window u_win_ss (.clk, .nominal(start_space_r), .fac, .dur(dur_sc), .hit(hit_ss));
  pdir_window u_win_bm (.clk, .nominal(bit_mark_r),    .fac, .dur(dur_sc), .hit(hit_bm));
  pdir_window u_win_1  (.clk, .nominal(one_space_r),   .fac, .dur(dur_sc), .hit(hit_one));
  pdir_window u_win_0  (.clk, .nominal(zero_space_r),  .fac, .dur(dur_sc), .hit(hit_zero));

  assign fire     = ir_valid_r && (!out_valid_r || out_ready);
  assign in_ready = !ir_valid_r || fire;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ir_valid_r <= 1'b0;
    end else if (in_ready) begin
      ir_valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      ir_mark_r <= in_is_mark;
      ir_dur_r  <= in_duration_us;
    end
  end

  assign shift_in = frame_t'({shift_r, hit_one});

  always_comb begin
    phase_nxt  = phase_r;
    bits_nxt   = bits_r;
    shift_nxt  = shift_r;
    res_valid  = 1'b0;
    res_status = 1'b0;
    res_data   = '0;
    unique case (phase_r)
      PH_START_MARK: begin
        if (ir_mark_r && hit_sm) begin
          phase_nxt = PH_START_SPACE;
        end
      end
      PH_START_SPACE: begin
        if (!ir_mark_r && hit_ss) begin
          phase_nxt = PH_BIT_MARK;
        end else begin
          res_valid = 1'b1;
        end
      end
      PH_BIT_MARK: begin
        if (ir_mark_r && hit_bm) begin
          phase_nxt = PH_BIT_SPACE;
        end else begin
          res_valid = 1'b1;
        end
      end
      PH_BIT_SPACE: begin
        if (!ir_mark_r && (hit_one || hit_zero)) begin
          if (bits_r == cnt_t'(FRAME_BITS - 1)) begin
            res_valid = 1'b1;
            res_data  = fdata_t'(shift_in);
            phase_nxt = PH_START_MARK;
            bits_nxt  = '0;
            shift_nxt = '0;
          end else begin
            phase_nxt = PH_BIT_MARK;
            bits_nxt  = cnt_t'(bits_r + 1'b1);
            shift_nxt = shift_in;
          end
        end else begin
          res_valid = 1'b1;
        end
      end
      default: begin
        phase_nxt = PH_START_MARK;
      end
    endcase
    if (res_valid && res_data == '0 && phase_nxt != PH_START_MARK) begin
      res_status = 1'b1;
    end
    if (res_valid && phase_nxt != PH_START_MARK) begin
      phase_nxt = PH_START_MARK;
      bits_nxt  = '0;
      shift_nxt = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= PH_START_MARK;
      bits_r  <= '0;
      shift_r <= '0;
    end else if (fire) begin
      phase_r <= phase_nxt;
      bits_r  <= bits_nxt;
      shift_r <= shift_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (fire && res_valid) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (fire && res_valid) begin
      out_frame_data_r <= res_data;
      out_status_r     <= res_status;
    end
  end

  assign out_valid      = out_valid_r;
  assign out_frame_data = out_frame_data_r;
  assign out_status     = out_status_r;

  a_err_data_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_status_r |-> out_frame_data_r == '0)
    else $error("error result carries nonzero frame data");

  a_bits_range: assert property (@(posedge clk) disable iff (!rst_n)
    bits_r < cnt_t'(FRAME_BITS))
    else $error("bit count beyond frame length");

  a_idle_clear: assert property (@(posedge clk) disable iff (!rst_n)
    (phase_r == PH_START_MARK || phase_r == PH_START_SPACE) |-> bits_r == '0 && shift_r == '0)
    else $error("frame state not cleared before bits");

  a_result_idle: assert property (@(posedge clk) disable iff (!rst_n)
    fire && res_valid |=> phase_r == PH_START_MARK)
    else $error("decoder not idle after a result");

endmodule

>>> hdl/pdir_window.sv
// ----------------------------------------------------------------------------
// pdir_window
// Tolerance window match of one nominal length. The scaled bounds are
// registered from the configuration; the duration compare is combinational.
// ----------------------------------------------------------------------------
module pdir_window (
  input  logic                  clk,
  input  pdir_pkg::nom_t        nominal,
  input  pdir_pkg::tol_fac_t    fac,
  input  pdir_pkg::dur_scaled_t dur,
  output logic                  hit
);
  import pdir_pkg::*;

  prod_t lo_r;
  prod_t hi_r;
  prod_t lo_nxt;
  prod_t hi_nxt;

  assign lo_nxt = prod_t'(nominal) * prod_t'(fac.lo);
  assign hi_nxt = prod_t'(nominal) * prod_t'(fac.hi);

  always_ff @(posedge clk) begin
    lo_r <= lo_nxt;
    hi_r <= hi_nxt;
  end

  // floor(lo/100) <= d  <=>  lo <= 100*d + 99;  d <= floor(hi/100)  <=>  100*d <= hi
  assign hit = (cmp_t'(lo_r) <= dur.top) && (dur.base <= cmp_t'(hi_r));

endmodule
